// File: rtl/core/tga_rle_row_decoder_top_defines.svh
// Assertion macros shared by the checker of the TGA run-length row decoder.
`ifndef TGA_RLE_ROW_DECODER_TOP_DEFINES_SVH
`define TGA_RLE_ROW_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGARLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGARLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tgarle_pkg.sv
// Types and constants shared by the TGA run-length row decoder modules.
package tgarle_pkg;

    localparam int unsigned ROW_W   = 18;
    localparam int unsigned PIX_W   = 32;
    localparam int unsigned COUNT_W = 8;

    // Decoder phase codes.
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_REPEAT = 2'd1;
    localparam logic [1:0] PH_RAW    = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_BPP = 1'b0;
    localparam logic CFG_ROW = 1'b1;

    localparam logic [2:0]       BPP_RESET = 3'd3;
    localparam logic [ROW_W-1:0] ROW_RESET = 18'd1920;

    typedef struct packed {
        logic [1:0]         phase;
        logic [COUNT_W-1:0] pixels_left;
        logic [1:0]         byte_index;
        logic [PIX_W-1:0]   pixel_accum;
        logic [ROW_W-1:0]   bytes_remaining;
        logic [COUNT_W-1:0] run_length;
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [PIX_W-1:0]   pixel;
        logic [COUNT_W-1:0] repeat_res;
        logic               last_of_row;
        logic               overrun;
    } result_t;

endpackage

// File: rtl/core/tgarle_step.sv
// Next-state and result logic for one byte of the run-length stream.
module tgarle_step (
    input  tgarle_pkg::state_t                 state,
    input  logic [7:0]                         data_byte,
    input  logic [2:0]                         bytes_per_pixel,
    input  logic [tgarle_pkg::ROW_W-1:0]       row_bytes,
    output tgarle_pkg::state_t                 state_next,
    output tgarle_pkg::result_t                result
);
    import tgarle_pkg::*;

    logic [2:0]         bpp_eff;
    logic [COUNT_W-1:0] count;
    logic [10:0]        need;
    logic [PIX_W-1:0]   accum_new;
    logic [COUNT_W-1:0] left_new;
    logic [1:0]         phase_new;

    // Out-of-range pixel sizes clamp to 1 or 4 bytes.
    always_comb
    begin
        if (bytes_per_pixel == 3'd0)
        begin
            bpp_eff = 3'd1;
        end
        else if (bytes_per_pixel > 3'd4)
        begin
            bpp_eff = 3'd4;
        end
        else
        begin
            bpp_eff = bytes_per_pixel;
        end
    end

    assign count     = {1'b0, data_byte[6:0]} + 8'd1;
    assign need      = {3'b000, count} * {8'h00, bpp_eff};
    assign accum_new = state.pixel_accum
                     | ({24'h000000, data_byte} << {state.byte_index, 3'b000});
    assign left_new  = (state.phase == PH_REPEAT) ? 8'd0 : (state.pixels_left - 8'd1);
    assign phase_new = (left_new == 8'd0) ? PH_HEADER : state.phase;

    always_comb
    begin
        state_next = state;
        result     = '0;
        case (state.phase)
            PH_HEADER:
            begin
                state_next.pixels_left = '0;
                state_next.byte_index  = '0;
                state_next.pixel_accum = '0;
                if ({7'd0, need} > state.bytes_remaining)
                begin
                    // The packet does not fit the row: drop it and restart the row.
                    state_next.bytes_remaining = row_bytes;
                    result.valid               = 1'b1;
                    result.overrun             = 1'b1;
                end
                else
                begin
                    state_next.bytes_remaining = state.bytes_remaining - {7'd0, need};
                    state_next.phase           = data_byte[7] ? PH_REPEAT : PH_RAW;
                    state_next.pixels_left     = count;
                    state_next.run_length      = count;
                end
            end
            default:
            begin
                if (({1'b0, state.byte_index} + 3'd1) < bpp_eff)
                begin
                    state_next.pixel_accum = accum_new;
                    state_next.byte_index  = state.byte_index + 2'd1;
                end
                else
                begin
                    state_next.pixel_accum = '0;
                    state_next.byte_index  = '0;
                    state_next.pixels_left = left_new;
                    state_next.phase       = phase_new;
                    result.valid           = 1'b1;
                    result.pixel           = accum_new;
                    result.repeat_res      = (state.phase == PH_REPEAT) ? state.run_length
                                                                        : 8'd1;
                    if ((phase_new == PH_HEADER) && (state.bytes_remaining == '0))
                    begin
                        result.last_of_row         = 1'b1;
                        state_next.bytes_remaining = row_bytes;
                    end
                end
            end
        endcase
    end

endmodule

// File: rtl/core/tga_rle_row_decoder_top.sv
// Top level of the TGA run-length row decoder.
// The decoder takes one compressed byte per cycle unless the input stalls: each
// byte is decoded in the cycle it is accepted, so the decoder state loop closes
// through the state register alone, and a completed pixel appears in the output
// register on the next cycle. A header byte that fits the row, or a pixel byte
// that does not finish a pixel, yields no result. The input stalls only while a
// result is held in the output register by a downstream stall. Configuration
// writes are always ready; a new row size applies from the next row start, or at
// once when no byte of the current row has been consumed.
module tga_rle_row_decoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tgarle_pkg::PIX_W-1:0]  pixel,
    output logic [7:0]                    repeat_res,
    output logic                          last_of_row,
    output logic                          overrun,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [tgarle_pkg::ROW_W-1:0]  cfg_data
);
    import tgarle_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    state_t           step_next;
    result_t          step_res;
    logic [2:0]       bpp_reg;
    logic [ROW_W-1:0] row_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;
    logic             in_take;
    logic             cfg_take;

    tgarle_step u_step (
        .state           (state_reg),
        .data_byte       (data_byte),
        .bytes_per_pixel (bpp_reg),
        .row_bytes       (row_reg),
        .state_next      (step_next),
        .result          (step_res)
    );

    assign in_stall  = out_valid_reg & out_stall;
    assign in_take   = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid & cfg_ready;

    always_comb
    begin
        state_next = state_reg;
        if (in_take)
        begin
            state_next = step_next;
        end
        else if (cfg_take && (cfg_index == CFG_ROW) && (state_reg.phase == PH_HEADER)
                 && (state_reg.bytes_remaining == row_reg))
        begin
            // Nothing of this row consumed yet, so the new size applies now.
            state_next.bytes_remaining = cfg_data;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (!in_stall)
        begin
            out_valid_next = in_take & step_res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase:           PH_HEADER,
                               pixels_left:     '0,
                               byte_index:      '0,
                               pixel_accum:     '0,
                               bytes_remaining: ROW_RESET,
                               run_length:      '0};
            bpp_reg       <= BPP_RESET;
            row_reg       <= ROW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_take)
            begin
                case (cfg_index)
                    CFG_BPP: bpp_reg <= cfg_data[2:0];
                    CFG_ROW: row_reg <= cfg_data;
                    default: row_reg <= row_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && step_res.valid)
        begin
            out_reg <= step_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel       = out_reg.pixel;
    assign repeat_res  = out_reg.repeat_res;
    assign last_of_row = out_reg.last_of_row;
    assign overrun     = out_reg.overrun;

endmodule

// File: rtl/core/tgarle_chk.sv
// Port-level checker for the TGA run-length row decoder, bound to the top level.
`include "tga_rle_row_decoder_top_defines.svh"

module tgarle_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [tgarle_pkg::PIX_W-1:0]  pixel,
    input logic [7:0]                    repeat_res,
    input logic                          last_of_row,
    input logic                          overrun
);
    import tgarle_pkg::*;

    // A stalled result stays in place until it is taken.
    `TGARLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel) && $stable(repeat_res) && $stable(last_of_row) && $stable(overrun), "stalled result changed")

    // An error result carries no pixel, no count and no row end.
    `TGARLE_ASSERT_NOW(a_overrun_clean, out_valid && overrun, (pixel == '0) && (repeat_res == 8'd0) && !last_of_row, "malformed overrun result")

    // Every pixel result repeats at least once.
    `TGARLE_ASSERT_NOW(a_repeat_nonzero, out_valid && !overrun, repeat_res != 8'd0, "pixel result with zero count")

    // A result only appears after a request was accepted.
    `TGARLE_ASSERT_NEXT(a_no_spurious, !out_valid && !(in_valid && !in_stall), !out_valid, "result without a request")

endmodule

bind tga_rle_row_decoder_top tgarle_chk u_tgarle_chk (.*);

// File: sim/tb_tga_rle_row_decoder_top.sv
// Self-checking testbench for the TGA run-length row decoder top level.
`timescale 1ns / 100ps

module tb_tga_rle_row_decoder_top;
    import tgarle_pkg::*;

    localparam int unsigned MAX_ROW_BYTES = 262144;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [COUNT_W-1:0] repeat_cnt;
        logic               last;
        logic               ovr;
    } decoded_pixel_t;

    typedef enum logic {STEP_BYTE, STEP_REG} step_kind_t;

    typedef struct packed {
        step_kind_t     kind;
        logic           reg_idx;
        logic [17:0]    value;
        logic           typed;
        decoded_pixel_t want;
    } dir_step_t;

    // Directed opening: tiny rows, overruns, a zero row, odd pixel sizes and
    // a pixel size change in the middle of a pixel.
    localparam dir_step_t DIRECTED [27] = '{
        '{STEP_REG,  CFG_BPP, 18'd1,      1'b0, '0},
        '{STEP_REG,  CFG_ROW, 18'd4,      1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'h81,     1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'hA5,     1'b1, '{32'h0000_00A5, 8'd2, 1'b0, 1'b0}},
        '{STEP_BYTE, CFG_BPP, 18'h01,     1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'h00,     1'b1, '{32'h0000_0000, 8'd1, 1'b0, 1'b0}},
        '{STEP_BYTE, CFG_BPP, 18'hFF,     1'b1, '{32'h0000_00FF, 8'd1, 1'b1, 1'b0}},
        '{STEP_BYTE, CFG_BPP, 18'h7F,     1'b1, '{32'h0, 8'd0, 1'b0, 1'b1}},
        '{STEP_BYTE, CFG_BPP, 18'hFF,     1'b1, '{32'h0, 8'd0, 1'b0, 1'b1}},
        '{STEP_REG,  CFG_BPP, 18'd0,      1'b0, '0},
        '{STEP_REG,  CFG_ROW, 18'd0,      1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'h00,     1'b1, '{32'h0, 8'd0, 1'b0, 1'b1}},
        '{STEP_REG,  CFG_BPP, 18'd7,      1'b0, '0},
        '{STEP_REG,  CFG_ROW, 18'h3FFFF,  1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'h80,     1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'h11,     1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'h22,     1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'h33,     1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'h44,     1'b1, '{32'h4433_2211, 8'd1, 1'b0, 1'b0}},
        '{STEP_REG,  CFG_BPP, 18'd2,      1'b0, '0},
        '{STEP_REG,  CFG_ROW, 18'd6,      1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'h01,     1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'h12,     1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'h34,     1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'h56,     1'b0, '0},
        '{STEP_REG,  CFG_BPP, 18'd1,      1'b0, '0},
        '{STEP_BYTE, CFG_BPP, 18'h78,     1'b0, '0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         data_byte;
    logic               out_valid;
    logic               out_stall;
    logic [PIX_W-1:0]   pixel;
    logic [7:0]         repeat_res;
    logic               last_of_row;
    logic               overrun;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [ROW_W-1:0]   cfg_data;

    // Decoder state as the testbench tracks it.
    logic [1:0]         dec_phase  = PH_HEADER;
    int unsigned        pix_left   = 0;
    int unsigned        byte_idx   = 0;
    logic [31:0]        accum      = '0;
    int unsigned        row_left   = ROW_RESET;
    int unsigned        run_len    = 0;
    logic [2:0]         bpp_reg    = BPP_RESET;
    logic [ROW_W-1:0]   row_reg    = ROW_RESET;

    decoded_pixel_t     pixel_q[$];
    decoded_pixel_t     oldest;
    int unsigned        mismatches     = 0;
    int unsigned        send_idle_pct  = 0;
    int unsigned        recv_stall_pct = 0;
    int unsigned        hold_left      = 0;
    int unsigned        cycle_count    = 0;

    tga_rle_row_decoder_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel       (pixel),
        .repeat_res  (repeat_res),
        .last_of_row (last_of_row),
        .overrun     (overrun),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned pixel_bytes();
        if (bpp_reg == 3'd0)
            return 1;
        if (bpp_reg > 3'd4)
            return 4;
        return bpp_reg;
    endfunction

    function automatic int unsigned row_len();
        if (row_reg > MAX_ROW_BYTES)
            return MAX_ROW_BYTES;
        return row_reg;
    endfunction

    // Advances the tracked state by one stream byte; returns 1 when a result
    // is due and fills it in.
    function automatic bit decode_stream_byte(input logic [7:0] b, output decoded_pixel_t res);
        int unsigned bpp;
        int unsigned count;
        int unsigned need;
        bpp = pixel_bytes();
        res = '0;
        if (dec_phase == PH_HEADER)
        begin
            count = b[6:0] + 1;
            need  = count * bpp;
            if (need > row_left)
            begin
                // The header is dropped and the row starts over.
                row_left = row_len();
                pix_left = 0;
                byte_idx = 0;
                accum    = '0;
                res.ovr  = 1'b1;
                return 1'b1;
            end
            row_left -= need;
            dec_phase = b[7] ? PH_REPEAT : PH_RAW;
            pix_left  = count;
            run_len   = count;
            byte_idx  = 0;
            accum     = '0;
            return 1'b0;
        end
        accum |= 32'(b) << (8 * byte_idx[1:0]);
        if (byte_idx + 1 < bpp)
        begin
            byte_idx = (byte_idx + 1) & 3;
            return 1'b0;
        end
        res.pixel = accum;
        if (dec_phase == PH_REPEAT)
        begin
            res.repeat_cnt = run_len[7:0];
            pix_left = 0;
        end
        else
        begin
            res.repeat_cnt = 8'd1;
            pix_left = (pix_left - 1) & 255;
        end
        byte_idx = 0;
        accum    = '0;
        if (pix_left == 0)
            dec_phase = PH_HEADER;
        res.last = (dec_phase == PH_HEADER) && (row_left == 0);
        if (res.last)
            row_left = row_len();
        return 1'b1;
    endfunction

    function automatic void apply_reg_write(input logic idx, input logic [ROW_W-1:0] v);
        bit fresh;
        if (idx == CFG_BPP)
        begin
            bpp_reg = v[2:0];
        end
        else
        begin
            // A row size takes hold at once only when the row has not begun.
            fresh   = (dec_phase == PH_HEADER) && (row_left == row_len());
            row_reg = v;
            if (fresh)
                row_left = row_len();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pixel_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ROW_W-1:0] v);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg_write(idx, v);
    endtask

    // Offers one byte, waits for the request to be taken and queues what it
    // should produce. A typed expectation replaces the computed one.
    task automatic send_byte(input logic [7:0] b, input bit typed, input decoded_pixel_t typed_res);
        decoded_pixel_t res;
        bit             has_res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        has_res = decode_stream_byte(b, res);
        if (typed)
            pixel_q.push_back(typed_res);
        else if (has_res)
            pixel_q.push_back(res);
    endtask

    // Mostly well-formed packets that fit the row, with random pixel bytes
    // and some random headers that tend to overrun.
    task automatic run_random(input int unsigned n);
        logic [7:0]  b;
        int unsigned maxc;
        int unsigned count;
        repeat (n)
        begin
            if (dec_phase == PH_HEADER && $urandom_range(99) < 85)
            begin
                maxc = row_left / pixel_bytes();
                if (maxc > 128)
                    maxc = 128;
                if (maxc == 0)
                begin
                    b = 8'($urandom_range(255));
                end
                else
                begin
                    if ($urandom_range(3) == 0)
                        count = $urandom_range(maxc, 1);
                    else
                        count = $urandom_range((maxc < 4) ? maxc : 4, 1);
                    b = {1'($urandom_range(1)), 7'(count - 1)};
                end
            end
            else
            begin
                b = 8'($urandom_range(255));
            end
            send_byte(b, 1'b0, '0);
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pixel_q.size() == 0)
            begin
                report_mismatch("result with none expected, pixel", pixel, 32'h0);
            end
            else
            begin
                oldest = pixel_q.pop_front();
                if (pixel !== oldest.pixel)
                    report_mismatch("pixel", pixel, oldest.pixel);
                if (repeat_res !== oldest.repeat_cnt)
                    report_mismatch("repeat_res", 32'(repeat_res), 32'(oldest.repeat_cnt));
                if (last_of_row !== oldest.last)
                    report_mismatch("last_of_row", 32'(last_of_row), 32'(oldest.last));
                if (overrun !== oldest.ovr)
                    report_mismatch("overrun", 32'(overrun), 32'(oldest.ovr));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int unsigned  round;
        logic [17:0]  row_val;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = CFG_BPP;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == STEP_REG)
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
            else
                send_byte(DIRECTED[i].value[7:0], DIRECTED[i].typed, DIRECTED[i].want);
        end

        for (round = 0; round < 12; round++)
        begin
            case (round % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            write_reg(CFG_BPP, (round < 8) ? 18'(round) : 18'($urandom_range(7)));
            case (round)
                1: row_val = 18'd1;
                3: row_val = 18'd0;
                5: row_val = 18'h3FFFF;
                default:
                begin
                    row_val = 18'(pixel_bytes() * $urandom_range(16, 1));
                    if ($urandom_range(3) == 0)
                        row_val = row_val + 18'($urandom_range(3));
                end
            endcase
            write_reg(CFG_ROW, row_val);
            run_random($urandom_range(70, 50));
        end

        // Long receiver hold-off while the sender keeps offering bytes, then
        // a pause until every pending result is out.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(CFG_BPP, 18'd2);
        write_reg(CFG_ROW, 18'd24);
        hold_left = 300;
        run_random(40);
        wait_for_results();
        recv_stall_pct = 30;
        run_random(20);

        wait_for_results();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/tgarle_pkg.sv
rtl/core/tgarle_step.sv
rtl/core/tga_rle_row_decoder_top.sv
rtl/core/tgarle_chk.sv
sim/tb_tga_rle_row_decoder_top.sv
